FILE: hw/rtl/tpwm_pkg.sv
// Shared types, constants and the window compare for the track window matcher.
`timescale 1ns / 1ps

package tpwm_pkg;

  localparam int MAX_COMPARISON_DEF = 32;
  localparam int RESULT_LIMIT       = 32;
  localparam int CIDX_W             = 5;
  localparam int PAR_W              = 20;
  localparam int WIN_W              = 19;
  localparam int CFG_ADDR_W         = 2;

  // item kinds carried on the slave tuser
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_MATCH = 2'd2;

  // config register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PHI  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CURV = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_Z    = 2'd3;

  localparam logic [WIN_W-1:0] PHI_WIN_RST  = 19'd786;
  localparam logic [WIN_W-1:0] COT_WIN_RST  = 19'd262;
  localparam logic [WIN_W-1:0] CURV_WIN_RST = 19'd2684;
  localparam logic [WIN_W-1:0] Z_WIN_RST    = 19'd819;

  // azimuth sits in the lowest bits
  typedef struct packed {
    logic signed [PAR_W-1:0] z_impact;
    logic signed [PAR_W-1:0] curv;
    logic signed [PAR_W-1:0] cot_theta;
    logic signed [PAR_W-1:0] azimuth;
  } track_t;

  typedef struct packed {
    logic [WIN_W-1:0] phi;
    logic [WIN_W-1:0] cot;
    logic [WIN_W-1:0] curv;
    logic [WIN_W-1:0] z;
  } win_t;

  typedef struct packed {
    logic shift;
    logic kill;
  } cell_ctrl_t;

  // |a - b| < w, difference formed exactly in 21 bits
  function automatic logic in_window(logic signed [PAR_W-1:0] a,
                                     logic signed [PAR_W-1:0] b,
                                     logic [WIN_W-1:0] w);
    logic signed [PAR_W:0] diff;
    logic [PAR_W:0] mag;
    diff = {a[PAR_W-1], a} - {b[PAR_W-1], b};
    mag  = diff[PAR_W] ? (PAR_W+1)'(-diff) : (PAR_W+1)'(diff);
    return mag < {2'b00, w};
  endfunction

endpackage

FILE: hw/rtl/tpwm_cell.sv
// One chain cell: a stored track plus the reference token passing through.
`timescale 1ns / 1ps

module tpwm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tpwm_pkg::cell_ctrl_t ctrl_i,
  input  logic                tok_i,
  input  tpwm_pkg::track_t    ref_i,
  input  logic                wr_i,
  input  tpwm_pkg::track_t    wr_data_i,
  input  tpwm_pkg::win_t      win_i,
  output logic                tok_o,
  output tpwm_pkg::track_t    ref_o,
  output logic                hit_o
);
  import tpwm_pkg::*;

  logic   tok_q;
  track_t ref_q;
  track_t trk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else if (ctrl_i.kill) begin
      tok_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      ref_q <= ref_i;
    end
    if (wr_i) begin
      trk_q <= wr_data_i;
    end
  end

  assign tok_o = tok_q;
  assign ref_o = ref_q;
  assign hit_o = tok_q
               && in_window(trk_q.azimuth,   ref_q.azimuth,   win_i.phi)
               && in_window(trk_q.cot_theta, ref_q.cot_theta, win_i.cot)
               && in_window(trk_q.curv,      ref_q.curv,      win_i.curv)
               && in_window(trk_q.z_impact,  ref_q.z_impact,  win_i.z);

endmodule

FILE: hw/rtl/track_parameter_window_match.sv
// Top level: track store as a chain of cells, scan control and result register.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata: tracks, tuser: op
//  m_axis    out  tvalid/tready           tdata: comp_index, tuser: flags, tlast
//  cfg       in   cfg_we_i                cfg_addr_i, cfg_wdata_i
//
// Clear, load and unused items are handled on acceptance; the input stays ready for the next item.
// A reference scans limit = min(stored tracks, 32) cells: the token walks the cell
// chain one cell per cycle, then a final step emits the last result.
// Each scan step waits while the result register is full and not being taken.
// Reset empties the store and loads the default windows; no clearing pass.
`timescale 1ns / 1ps

module track_parameter_window_match #(
  parameter int MaxComparison = tpwm_pkg::MAX_COMPARISON_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // azimuth [19:0], cot_theta [39:20], curv [59:40], z_impact [79:60]
  input  logic [79:0]                       s_axis_tdata,
  // op [1:0]
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // comp_index [4:0], zero [7:5]
  output logic [7:0]                        m_axis_tdata,
  // matched [0], loads_dropped [1]
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [tpwm_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [tpwm_pkg::WIN_W-1:0]        cfg_wdata_i
);
  import tpwm_pkg::*;

  localparam int CntW = $clog2(MaxComparison + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic              drop_q;
  logic [CIDX_W-1:0] idx_q;
  logic [CIDX_W-1:0] last_q;
  logic              pend_v_q;
  logic [CIDX_W-1:0] pend_idx_q;
  logic              out_valid_q;
  logic              out_matched_q;
  logic [CIDX_W-1:0] out_idx_q;
  logic              out_last_q;
  logic              out_drop_q;
  win_t              win_q;

  logic              in_acc;
  logic              out_free;
  logic              out_load;
  logic              step;
  logic              last_step;
  logic              inject;
  logic              hit;
  logic [CIDX_W-1:0] last_idx;
  cell_ctrl_t        ctrl;
  track_t            in_trk;

  logic [MaxComparison-1:0] tok_vec;
  logic [MaxComparison-1:0] hit_vec;
  logic [MaxComparison-1:0] wr_vec;
  track_t                   ref_vec [MaxComparison];

  assign in_trk   = track_t'(s_axis_tdata);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign step     = (state_q == ST_SCAN) && out_free;
  assign last_step = step && (idx_q == last_q);
  assign inject   = in_acc && (s_axis_tuser == OP_MATCH) && (count_q != '0);
  assign hit      = |hit_vec;
  // a new beat enters the result register this cycle
  assign out_load = (step && hit && pend_v_q) || ((state_q == ST_FINAL) && out_free);

  assign ctrl.shift = inject || step;
  assign ctrl.kill  = last_step;

  // highest index scanned; only the first 32 tracks can be named
  assign last_idx = (count_q >= RESULT_LIMIT) ? CIDX_W'(RESULT_LIMIT - 1)
                                              : CIDX_W'(count_q - 1'b1);

  for (genvar i = 0; i < MaxComparison; i++) begin : g_cell
    logic   tok_in;
    track_t ref_in;
    if (i == 0) begin : g_head
      assign tok_in = inject;
      assign ref_in = in_trk;
    end else begin : g_link
      assign tok_in = tok_vec[i-1];
      assign ref_in = ref_vec[i-1];
    end
    assign wr_vec[i] = in_acc && (s_axis_tuser == OP_LOAD) && (count_q == CntW'(i));

    tpwm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .tok_i     (tok_in),
      .ref_i     (ref_in),
      .wr_i      (wr_vec[i]),
      .wr_data_i (in_trk),
      .win_i     (win_q),
      .tok_o     (tok_vec[i]),
      .ref_o     (ref_vec[i]),
      .hit_o     (hit_vec[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.phi  <= PHI_WIN_RST;
      win_q.cot  <= COT_WIN_RST;
      win_q.curv <= CURV_WIN_RST;
      win_q.z    <= Z_WIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_PHI:  win_q.phi  <= cfg_wdata_i;
        REG_COT:  win_q.cot  <= cfg_wdata_i;
        REG_CURV: win_q.curv <= cfg_wdata_i;
        REG_Z:    win_q.z    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      drop_q      <= 1'b0;
      idx_q       <= '0;
      last_q      <= '0;
      pend_v_q    <= 1'b0;
      pend_idx_q  <= '0;
      out_valid_q <= 1'b0;
      out_matched_q <= 1'b0;
      out_idx_q   <= '0;
      out_last_q  <= 1'b0;
      out_drop_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (s_axis_tuser)
              OP_CLEAR: begin
                count_q <= '0;
                drop_q  <= 1'b0;
              end
              OP_LOAD: begin
                if (count_q < CntW'(MaxComparison)) begin
                  count_q <= count_q + 1'b1;
                end else begin
                  drop_q <= 1'b1;
                end
              end
              OP_MATCH: begin
                idx_q    <= '0;
                last_q   <= last_idx;
                pend_v_q <= 1'b0;
                state_q  <= (count_q == '0) ? ST_FINAL : ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (out_free) begin
            // a hit is held back one match so the final one can carry tlast
            if (hit) begin
              if (pend_v_q) begin
                out_matched_q <= 1'b1;
                out_idx_q     <= pend_idx_q;
                out_last_q    <= 1'b0;
                out_drop_q    <= drop_q;
              end
              pend_v_q   <= 1'b1;
              pend_idx_q <= idx_q;
            end
            idx_q <= idx_q + 1'b1;
            if (idx_q == last_q) begin
              state_q <= ST_FINAL;
            end
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            out_matched_q <= pend_v_q;
            out_idx_q     <= pend_v_q ? pend_idx_q : '0;
            out_last_q    <= 1'b1;
            out_drop_q    <= drop_q;
            pend_v_q      <= 1'b0;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(8 - CIDX_W){1'b0}}, out_idx_q};
  assign m_axis_tuser  = {out_drop_q, out_matched_q};
  assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one reference token in the chain");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (tok_vec == '0 && !pend_v_q))
    else $error("token or pending hit left while idle");

  a_scan_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (tok_vec != '0))
    else $error("scanning without a token");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxComparison))
    else $error("stored count beyond capacity");

  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL && out_free) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("final step did not emit a last beat");
`endif

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the track parameter window matcher.
`timescale 1ns / 1ps

module tb;
  import tpwm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STORE_DEPTH = MAX_COMPARISON_DEF;
  localparam int DRAIN_CYCLES = RESULT_LIMIT + 8;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 55;
  localparam int NUM_PHASES = 7;
  localparam int PAR_MAX = 524287;
  localparam int PAR_MIN = -524288;
  localparam logic [WIN_W-1:0] WIN_MAX = '1;
  localparam logic [CFG_ADDR_W-1:0] REG_OF [4] = '{REG_PHI, REG_COT, REG_CURV, REG_Z};

  // [0] azimuth, [1] cot_theta, [2] curv, [3] z_impact; same order as the windows
  typedef logic [3:0][PAR_W-1:0] trk_t;
  typedef logic [3:0][WIN_W-1:0] wins_t;

  typedef struct packed {
    logic              matched;
    logic [CIDX_W-1:0] idx;
    logic              last;
    logic              dropped;
  } hit_t;

  typedef struct {
    logic [1:0] op;
    trk_t       trk;
    bit         typed;
    hit_t       want;
  } dir_row_t;

  localparam hit_t NO_HIT = '{1'b0, '0, 1'b1, 1'b0};
  localparam hit_t HIT_0  = '{1'b1, '0, 1'b1, 1'b0};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [79:0]           s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = OP_CLEAR;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = REG_PHI;
  logic [WIN_W-1:0]      cfg_wdata_i = '0;

  track_parameter_window_match uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // shadow of the block state
  trk_t  stored_trk [STORE_DEPTH];
  int    stored_n = 0;
  bit    drop_seen = 1'b0;
  wins_t win = {Z_WIN_RST, CURV_WIN_RST, COT_WIN_RST, PHI_WIN_RST};
  hit_t  expected_hits [$];

  dir_row_t dir_tab [$];
  bit no_idle = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int refs_sent = 0;
  int results_seen = 0;
  int matches_seen = 0;
  int dropped_seen = 0;
  int quiet_cycles = 0;

  function automatic bit in_win(input logic [PAR_W-1:0] a, input logic [PAR_W-1:0] b,
                                input logic [WIN_W-1:0] w);
    int d;
    d = int'($signed(a)) - int'($signed(b));
    if (d < 0) d = -d;
    return d < int'(w);
  endfunction

  function automatic void queue_hit(input hit_t h);
    expected_hits.insert(expected_hits.size(), h);
  endfunction

  // update the shadow state and queue the results one item produces
  function automatic void predict_results(input logic [1:0] op, input trk_t t);
    int hits [$];
    bit ok;
    case (op)
      OP_CLEAR: begin
        stored_n = 0;
        drop_seen = 1'b0;
      end
      OP_LOAD: begin
        if (stored_n < STORE_DEPTH) begin
          stored_trk[stored_n] = t;
          stored_n++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      OP_MATCH: begin
        for (int i = 0; i < stored_n && i < RESULT_LIMIT; i++) begin
          ok = 1'b1;
          for (int k = 0; k < 4; k++)
            if (!in_win(stored_trk[i][k], t[k], win[k])) ok = 1'b0;
          if (ok) hits.insert(hits.size(), i);
        end
        if (hits.size() == 0) queue_hit('{1'b0, '0, 1'b1, drop_seen});
        foreach (hits[j])
          queue_hit('{1'b1, CIDX_W'(hits[j]), j == hits.size() - 1, drop_seen});
      end
      default: ;
    endcase
  endfunction

  function automatic trk_t mk(input int a, input int c, input int k, input int z);
    return {PAR_W'(z), PAR_W'(k), PAR_W'(c), PAR_W'(a)};
  endfunction

  function automatic trk_t rand_trk();
    trk_t t;
    for (int k = 0; k < 4; k++) t[k] = PAR_W'($urandom());
    return t;
  endfunction

  // spread each field a little past its window
  function automatic trk_t jitter(input trk_t base);
    trk_t t;
    int span;
    for (int k = 0; k < 4; k++) begin
      span = int'(win[k]) + int'(win[k]) / 4 + 1;
      t[k] = PAR_W'(int'($signed(base[k])) + int'($urandom_range(0, 2 * span)) - span);
    end
    return t;
  endfunction

  function automatic trk_t near_ref(input trk_t center);
    trk_t base;
    trk_t t;
    int k;
    int off;
    base = (stored_n > 0) ? stored_trk[$urandom_range(0, stored_n - 1)] : center;
    t = jitter(base);
    // put one field right on or just inside the window edge
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, 3);
      off = int'(win[k]) - int'($urandom_range(0, 1));
      if ($urandom_range(0, 1) == 1) off = -off;
      t[k] = PAR_W'(int'($signed(base[k])) + off);
    end
    return t;
  endfunction

  task automatic note_mismatch(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  task automatic add_row(input logic [1:0] op, input trk_t t, input bit typed,
                         input hit_t want);
    dir_row_t row;
    row = '{op, t, typed, want};
    dir_tab.insert(dir_tab.size(), row);
  endtask

  // leaves tvalid high on return so back-to-back beats need no extra edge
  task automatic send_beat(input logic [1:0] op, input trk_t t);
    while (!no_idle && $urandom_range(0, 99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= t;
    s_axis_tuser <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op != OP_UNUSED) items_sent++;
    if (op == OP_MATCH) refs_sent++;
  endtask

  task automatic issue(input logic [1:0] op, input trk_t t);
    send_beat(op, t);
    predict_results(op, t);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_windows(input wins_t w);
    for (int k = 0; k < 4; k++) begin
      cfg_we_i <= 1'b1;
      cfg_addr_i <= REG_OF[k];
      cfg_wdata_i <= w[k];
      @(posedge clk_i);
      win[k] = w[k];
    end
    cfg_we_i <= 1'b0;
  endtask

  // usually a clear, then a cluster of loads (sometimes past capacity), then references
  task automatic run_session();
    trk_t center;
    int pick;
    int n_load;
    center = rand_trk();
    if ($urandom_range(0, 9) != 0) issue(OP_CLEAR, rand_trk());
    pick = $urandom_range(0, 9);
    if (pick < 6) n_load = $urandom_range(0, 8);
    else if (pick < 8) n_load = $urandom_range(9, 31);
    else n_load = $urandom_range(32, 36);
    repeat (n_load) begin
      if ($urandom_range(0, 24) == 0) issue(OP_UNUSED, rand_trk());
      issue(OP_LOAD, jitter(center));
    end
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(0, 9) < 8) issue(OP_MATCH, near_ref(center));
      else issue(OP_MATCH, rand_trk());
    end
  endtask

  always @(posedge clk_i) m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 37);

  always @(posedge clk_i) begin
    hit_t got;
    hit_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser[0], m_axis_tdata[CIDX_W-1:0], m_axis_tlast, m_axis_tuser[1]};
      results_seen++;
      if (got.matched) matches_seen++;
      if (got.dropped) dropped_seen++;
      if (expected_hits.size() == 0) begin
        note_mismatch($sformatf("unexpected beat matched=%0b idx=%0d last=%0b dropped=%0b",
                                got.matched, got.idx, got.last, got.dropped));
      end else begin
        want = expected_hits.pop_front();
        if (got !== want || m_axis_tdata[7:CIDX_W] !== '0)
          note_mismatch($sformatf({"beat %0d: expected matched=%0b idx=%0d last=%0b ",
                                   "dropped=%0b, got matched=%0b idx=%0d last=%0b ",
                                   "dropped=%0b pad=%0h"},
                                  results_seen, want.matched, want.idx, want.last,
                                  want.dropped, got.matched, got.idx, got.last,
                                  got.dropped, m_axis_tdata[7:CIDX_W]));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[%0t] no beat moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("track_parameter_window_match test failed");
        $finish;
      end
    end
  end

  initial begin
    wins_t w;
    int target;

    // default windows: phi 786, cot 262, curv 2684, z 819
    add_row(OP_MATCH, mk(0, 0, 0, 0), 1'b1, NO_HIT);            // empty store
    add_row(OP_UNUSED, mk(-1, -1, -1, -1), 1'b0, '0);
    add_row(OP_MATCH, mk(0, 0, 0, 0), 1'b1, NO_HIT);            // unused op stored nothing
    add_row(OP_LOAD, mk(0, 0, 0, 0), 1'b0, '0);
    add_row(OP_MATCH, mk(0, 0, 0, 0), 1'b1, HIT_0);
    add_row(OP_MATCH, mk(785, 0, 0, 0), 1'b1, HIT_0);
    add_row(OP_MATCH, mk(786, 0, 0, 0), 1'b1, NO_HIT);          // strict compare
    add_row(OP_MATCH, mk(-786, 0, 0, 0), 1'b1, NO_HIT);
    add_row(OP_MATCH, mk(0, 261, 0, 0), 1'b1, HIT_0);
    add_row(OP_MATCH, mk(0, -262, 0, 0), 1'b1, NO_HIT);
    add_row(OP_MATCH, mk(0, 0, 2683, 0), 1'b1, HIT_0);          // curv diff is not halved
    add_row(OP_MATCH, mk(0, 0, 2684, 0), 1'b1, NO_HIT);
    add_row(OP_MATCH, mk(0, 0, 0, -818), 1'b1, HIT_0);
    add_row(OP_MATCH, mk(0, 0, 0, 819), 1'b1, NO_HIT);
    add_row(OP_LOAD, mk(PAR_MAX, PAR_MAX, PAR_MAX, PAR_MAX), 1'b0, '0);
    add_row(OP_LOAD, mk(PAR_MIN, PAR_MIN, PAR_MIN, PAR_MIN), 1'b0, '0);
    add_row(OP_LOAD, mk(10, -10, 100, -100), 1'b0, '0);
    add_row(OP_MATCH, mk(PAR_MAX, PAR_MAX, PAR_MAX, PAR_MAX), 1'b0, '0);
    add_row(OP_MATCH, mk(PAR_MIN, PAR_MIN, PAR_MIN, PAR_MIN), 1'b0, '0);
    add_row(OP_MATCH, mk(0, 0, 0, 0), 1'b0, '0);                // two hits, last on the second
    add_row(OP_CLEAR, mk(PAR_MIN, PAR_MAX, PAR_MIN, PAR_MAX), 1'b0, '0);
    add_row(OP_MATCH, mk(0, 0, 0, 0), 1'b1, NO_HIT);
    add_row(OP_UNUSED, mk(PAR_MIN, PAR_MIN, PAR_MIN, PAR_MIN), 1'b0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].typed) begin
        send_beat(dir_tab[r].op, dir_tab[r].trk);
        queue_hit(dir_tab[r].want);
      end else begin
        issue(dir_tab[r].op, dir_tab[r].trk);
      end
    end

    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      drain_results();
      no_idle = (ph == 6);
      for (int k = 0; k < 4; k++) begin
        case (ph)
          1: w[k] = WIN_MAX;
          2: w[k] = '0;
          3: w[k] = WIN_W'($urandom_range(1, 64));
          4: w[k] = WIN_W'($urandom());
          5: begin
            case ($urandom_range(0, 3))
              0: w[k] = '0;
              1: w[k] = WIN_MAX;
              2: w[k] = WIN_W'(1);
              default: w[k] = WIN_W'($urandom_range(0, 4000));
            endcase
          end
          6: w = {Z_WIN_RST, CURV_WIN_RST, COT_WIN_RST, PHI_WIN_RST};
          default: w[k] = WIN_W'($urandom_range(100, 5000));
        endcase
      end
      set_windows(w);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_session();
    end
    no_idle = 1'b0;
    drain_results();

    $display("%0d items (%0d references) over %0d window settings", items_sent, refs_sent,
             NUM_PHASES + 1);
    $display("%0d result beats checked: %0d matches, %0d with loads dropped, %0d mismatches",
             results_seen, matches_seen, dropped_seen, errors);
    if (errors == 0) $display("track_parameter_window_match test passed");
    else $display("track_parameter_window_match test failed");
    $finish;
  end

endmodule
